// ----- rtl/core/nhsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA heading parser package
// Character codes, sentence type selects and small decode helpers shared by
// the heading sentence parser.
// ----------------------------------------------------------------------------
package nhsp_pkg;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  // Sentence type selects.
  typedef enum logic [2:0] {
    TYPE_HDG  = 3'd0,
    TYPE_HDT  = 3'd1,
    TYPE_HDM  = 3'd2,
    TYPE_THS  = 3'd3,
    TYPE_PHDT = 3'd4,
    TYPE_CHDT = 3'd5,
    TYPE_EHDT = 3'd6,
    TYPE_NONE = 3'd7
  } heading_type_t;

  localparam heading_type_t TYPE_RESET = TYPE_HDT;

  // Heading accumulator holds values up to the cap of 65536 tenths.
  localparam int unsigned ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_CAP = 17'h10000;

  // Decoded hex digit: valid flag and nibble value.
  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.hit   = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.hit = 1'b0;
    end
    return h;
  endfunction

  // True when the last characters in the window spell the selected type.
  function automatic logic type_hit(input logic [31:0] window, input heading_type_t sel);
    logic hit;
    hit = 1'b0;
    case (sel)
      TYPE_HDG:  hit = (window[23:0] == 24'h484447);
      TYPE_HDT:  hit = (window[23:0] == 24'h484454);
      TYPE_HDM:  hit = (window[23:0] == 24'h48444D);
      TYPE_THS:  hit = (window[23:0] == 24'h544853);
      TYPE_PHDT: hit = (window == 32'h50484454);
      TYPE_CHDT: hit = (window == 32'h43484454);
      TYPE_EHDT: hit = (window == 32'h45484454);
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/nmea_heading_sentence_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA heading sentence parser
// Splits a character stream into lines, checks the NMEA checksum and sentence
// type of each line and extracts the heading field in tenths of a degree.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while byte_stall is low; the
// per-line state is updated by a single layer of logic on the accepted word.
// Every newline produces one result word (pass flag and heading register),
// registered into the output register, or into the skid entry when the output
// register holds a word not yet taken; this is the two-word output buffer, so
// characters keep flowing while a result waits; byte_stall rises only when
// both entries hold words not yet taken. The heading type register may be
// written at any time the block is idle; cfg_ready is always high.

module nmea_heading_sentence_parser_core #(
  parameter int unsigned CHECK_SPAN      = 128,
  parameter int unsigned FIELD_MAX_CHARS = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data,
  // Character channel.
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  byte_in,
  // Result channel.
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             sentence_ok,
  output logic [15:0]      heading_tenths
);

  localparam int unsigned ACC_W = nhsp_pkg::ACC_W;

  // Configuration register.
  nhsp_pkg::heading_type_t heading_type;

  // Per-line state.
  logic [7:0]       line_position, line_position_next;
  logic [7:0]       xor_accumulator, xor_accumulator_next;
  logic [7:0]       received_checksum, received_checksum_next;
  logic [1:0]       comma_count, comma_count_next;
  logic [3:0]       field_length, field_length_next;
  logic [ACC_W-1:0] value_tenths_accum, value_tenths_accum_next;
  logic [1:0]       fraction_digit_count, fraction_digit_count_next;
  logic             round_up_pending, round_up_pending_next;
  logic [31:0]      recent_bytes_window, recent_bytes_window_next;
  logic             type_matched, type_matched_next;
  logic             ck_fail, ck_fail_next;
  logic             star_seen, star_seen_next;
  logic             hex_ended, hex_ended_next;
  logic             nul_seen, nul_seen_next;
  logic             num_started, num_started_next;
  logic             num_negative, num_negative_next;
  logic             point_seen, point_seen_next;
  logic             num_ended, num_ended_next;
  logic [15:0]      heading_register, heading_register_next;

  // Output buffer.
  logic             skid_valid;
  logic             skid_ok;
  logic [15:0]      skid_heading;

  logic             byte_take;
  logic             result_take;
  logic             push;
  logic             push_ok;
  logic [15:0]      push_heading;

  assign cfg_ready   = 1'b1;
  assign byte_stall  = skid_valid;
  assign byte_take   = byte_valid && !byte_stall;
  assign result_take = result_valid && !result_stall;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_type <= nhsp_pkg::TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heading_type <= nhsp_pkg::heading_type_t'(cfg_data);
    end
  end

  // Per-character parse step.
  always_comb begin
    logic [7:0]          b;
    logic [7:0]          idx;
    logic [31:0]         window;
    nhsp_pkg::hex_digit_t h;
    logic [3:0]          digit;
    logic                is_digit;
    logic                is_blank;
    logic [19:0]         prod;
    logic [ACC_W:0]      rounded;

    b        = byte_in;
    idx      = line_position;
    window   = {recent_bytes_window[23:0], byte_in};
    h        = nhsp_pkg::hex_decode(byte_in);
    digit    = byte_in[3:0];
    is_digit = (byte_in >= nhsp_pkg::CHAR_ZERO) && (byte_in <= nhsp_pkg::CHAR_NINE);
    is_blank = (byte_in == nhsp_pkg::CHAR_SPACE) ||
               ((byte_in >= nhsp_pkg::CHAR_TAB) && (byte_in <= nhsp_pkg::CHAR_CR));
    prod     = 20'd0;
    rounded  = '0;

    line_position_next        = line_position;
    xor_accumulator_next      = xor_accumulator;
    received_checksum_next    = received_checksum;
    comma_count_next          = comma_count;
    field_length_next         = field_length;
    value_tenths_accum_next   = value_tenths_accum;
    fraction_digit_count_next = fraction_digit_count;
    round_up_pending_next     = round_up_pending;
    recent_bytes_window_next  = recent_bytes_window;
    type_matched_next         = type_matched;
    ck_fail_next              = ck_fail;
    star_seen_next            = star_seen;
    hex_ended_next            = hex_ended;
    nul_seen_next             = nul_seen;
    num_started_next          = num_started;
    num_negative_next         = num_negative;
    point_seen_next           = point_seen;
    num_ended_next            = num_ended;
    heading_register_next     = heading_register;
    push                      = 1'b0;
    push_ok                   = 1'b0;
    push_heading              = heading_register;

    if (byte_take) begin
      if (b == nhsp_pkg::CHAR_NEWLINE) begin
        // End of line: judge it, update the heading and clear the line state.
        push    = 1'b1;
        push_ok = star_seen && !ck_fail && (received_checksum == xor_accumulator) &&
                  type_matched;
        if (push_ok) begin
          if (comma_count == 2'd2 && !num_negative) begin
            rounded = {1'b0, value_tenths_accum} + (ACC_W+1)'(round_up_pending);
            if (rounded > (ACC_W+1)'(16'hFFFF)) begin
              heading_register_next = 16'hFFFF;
            end else begin
              heading_register_next = rounded[15:0];
            end
          end else begin
            heading_register_next = 16'd0;
          end
        end
        push_heading = heading_register_next;

        line_position_next        = '0;
        xor_accumulator_next      = '0;
        received_checksum_next    = '0;
        comma_count_next          = '0;
        field_length_next         = '0;
        value_tenths_accum_next   = '0;
        fraction_digit_count_next = '0;
        round_up_pending_next     = 1'b0;
        recent_bytes_window_next  = '0;
        type_matched_next         = 1'b0;
        ck_fail_next              = 1'b0;
        star_seen_next            = 1'b0;
        hex_ended_next            = 1'b0;
        nul_seen_next             = 1'b0;
        num_started_next          = 1'b0;
        num_negative_next         = 1'b0;
        point_seen_next           = 1'b0;
        num_ended_next            = 1'b0;
      end else if (nul_seen) begin
        // Text after a NUL character is ignored until the newline.
      end else if (b == nhsp_pkg::CHAR_NUL) begin
        nul_seen_next = 1'b1;
      end else begin
        if (line_position != 8'hFF) begin
          line_position_next = line_position + 8'd1;
        end

        // Checksum framing: dollar, covered text, star, hex digits.
        if (!ck_fail) begin
          if (idx == 8'd0) begin
            if (b != nhsp_pkg::CHAR_DOLLAR) begin
              ck_fail_next = 1'b1;
            end
          end else if (!star_seen) begin
            if (b == nhsp_pkg::CHAR_STAR) begin
              star_seen_next = 1'b1;
            end else if (idx >= 8'(CHECK_SPAN)) begin
              ck_fail_next = 1'b1;
            end else begin
              xor_accumulator_next = xor_accumulator ^ b;
            end
          end else if (!hex_ended) begin
            if (!h.hit) begin
              hex_ended_next = 1'b1;
            end else begin
              received_checksum_next = {received_checksum[3:0], h.value};
            end
          end
        end

        // Sentence type search over the last four characters.
        recent_bytes_window_next = window;
        if (nhsp_pkg::type_hit(window, heading_type)) begin
          type_matched_next = 1'b1;
        end

        // Comma counting and heading field decode.
        if (b == nhsp_pkg::CHAR_COMMA) begin
          if (comma_count != 2'd2) begin
            comma_count_next = comma_count + 2'd1;
          end
        end else if (comma_count == 2'd1 && field_length < 4'(FIELD_MAX_CHARS)) begin
          field_length_next = field_length + 4'd1;
          if (num_ended) begin
            // Number already closed.
          end else if (!num_started && is_blank) begin
            // Leading white space is skipped.
          end else if (!num_started && (b == nhsp_pkg::CHAR_PLUS ||
                                        b == nhsp_pkg::CHAR_MINUS)) begin
            num_started_next = 1'b1;
            if (b == nhsp_pkg::CHAR_MINUS) begin
              num_negative_next = 1'b1;
            end
          end else if (is_digit) begin
            num_started_next = 1'b1;
            if (!point_seen) begin
              // Integer digit: acc * 10 + digit * 10, capped.
              if (value_tenths_accum >= nhsp_pkg::ACC_CAP) begin
                value_tenths_accum_next = nhsp_pkg::ACC_CAP;
              end else begin
                prod = {value_tenths_accum, 3'b000} + {2'b00, value_tenths_accum, 1'b0} +
                       20'({digit, 3'b000}) + 20'({digit, 1'b0});
                if (prod > 20'(nhsp_pkg::ACC_CAP)) begin
                  value_tenths_accum_next = nhsp_pkg::ACC_CAP;
                end else begin
                  value_tenths_accum_next = prod[ACC_W-1:0];
                end
              end
            end else if (fraction_digit_count == 2'd0) begin
              // Tenths digit.
              if (value_tenths_accum >= nhsp_pkg::ACC_CAP) begin
                value_tenths_accum_next = nhsp_pkg::ACC_CAP;
              end else begin
                prod = 20'(value_tenths_accum) + 20'(digit);
                if (prod > 20'(nhsp_pkg::ACC_CAP)) begin
                  value_tenths_accum_next = nhsp_pkg::ACC_CAP;
                end else begin
                  value_tenths_accum_next = prod[ACC_W-1:0];
                end
              end
              fraction_digit_count_next = 2'd1;
            end else if (fraction_digit_count == 2'd1) begin
              // Hundredths digit decides the rounding.
              if (digit >= 4'd5) begin
                round_up_pending_next = 1'b1;
              end
              fraction_digit_count_next = 2'd2;
            end
          end else if (b == nhsp_pkg::CHAR_POINT && !point_seen) begin
            point_seen_next  = 1'b1;
            num_started_next = 1'b1;
          end else begin
            num_ended_next = 1'b1;
          end
        end
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position        <= '0;
      xor_accumulator      <= '0;
      received_checksum    <= '0;
      comma_count          <= '0;
      field_length         <= '0;
      value_tenths_accum   <= '0;
      fraction_digit_count <= '0;
      round_up_pending     <= 1'b0;
      recent_bytes_window  <= '0;
      type_matched         <= 1'b0;
      ck_fail              <= 1'b0;
      star_seen            <= 1'b0;
      hex_ended            <= 1'b0;
      nul_seen             <= 1'b0;
      num_started          <= 1'b0;
      num_negative         <= 1'b0;
      point_seen           <= 1'b0;
      num_ended            <= 1'b0;
      heading_register     <= '0;
    end else begin
      line_position        <= line_position_next;
      xor_accumulator      <= xor_accumulator_next;
      received_checksum    <= received_checksum_next;
      comma_count          <= comma_count_next;
      field_length         <= field_length_next;
      value_tenths_accum   <= value_tenths_accum_next;
      fraction_digit_count <= fraction_digit_count_next;
      round_up_pending     <= round_up_pending_next;
      recent_bytes_window  <= recent_bytes_window_next;
      type_matched         <= type_matched_next;
      ck_fail              <= ck_fail_next;
      star_seen            <= star_seen_next;
      hex_ended            <= hex_ended_next;
      nul_seen             <= nul_seen_next;
      num_started          <= num_started_next;
      num_negative         <= num_negative_next;
      point_seen           <= point_seen_next;
      num_ended            <= num_ended_next;
      heading_register     <= heading_register_next;
    end
  end

  // Output buffer control: output register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_take) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      if (!result_valid) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (result_take) begin
      if (skid_valid) begin
        sentence_ok    <= skid_ok;
        heading_tenths <= skid_heading;
        if (push) begin
          skid_ok      <= push_ok;
          skid_heading <= push_heading;
        end
      end else if (push) begin
        sentence_ok    <= push_ok;
        heading_tenths <= push_heading;
      end
    end else if (push) begin
      if (!result_valid) begin
        sentence_ok    <= push_ok;
        heading_tenths <= push_heading;
      end else begin
        skid_ok      <= push_ok;
        skid_heading <= push_heading;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/nmea_heading_sentence_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA heading sentence parser testbench
// Feeds the parser a character stream of short directed lines followed by
// randomized sentences: mostly well-formed NMEA sentences with random talkers,
// types, heading fields and checksum spellings, plus broken sentences and raw
// noise. A scoreboard class predicts the pass flag and heading register for
// every newline and checks each result word in order, while both sides of the
// block idle at random and the heading type register is swept between phases.
// ----------------------------------------------------------------------------
module nmea_heading_sentence_parser_core_tb;

  localparam int unsigned CHECK_SPAN      = 128;
  localparam int unsigned FIELD_MAX_CHARS = 15;
  localparam int unsigned TENTHS_CAP      = 65536;
  localparam int unsigned CHAR_TARGET     = 1920;
  localparam int unsigned PHASE_CHARS     = 220;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  // Cycles the block may still need after its last result word.
  localparam int unsigned SETTLE_CYCLES   = 8;

  localparam logic [7:0] BLANKS [5] = '{nhsp_pkg::CHAR_SPACE, nhsp_pkg::CHAR_TAB, 8'h0B,
                                        8'h0C, nhsp_pkg::CHAR_CR};
  localparam logic [2:0] PHASE_TYPES [8] = '{nhsp_pkg::TYPE_EHDT, nhsp_pkg::TYPE_HDG,
                                             nhsp_pkg::TYPE_NONE, nhsp_pkg::TYPE_HDM,
                                             nhsp_pkg::TYPE_PHDT, nhsp_pkg::TYPE_CHDT,
                                             nhsp_pkg::TYPE_THS, nhsp_pkg::TYPE_HDT};

  typedef struct {
    logic        ok;
    logic [15:0] heading;
  } sentence_result_t;

  // Line parser predictor with an in-order store of expected result words.
  class heading_scoreboard;
    nhsp_pkg::heading_type_t type_sel;
    logic [7:0]       line_pos;
    logic [7:0]       xor_acc;
    logic [7:0]       rx_ck;
    logic             ck_fail, star, hex_end, nul_seen;
    logic             num_go, neg, dot, num_end;
    logic [1:0]       commas;
    logic [3:0]       field_len;
    int unsigned      acc;
    logic [1:0]       frac_cnt;
    logic             round_up;
    logic [31:0]      window;
    logic             type_seen;
    logic [15:0]      heading;
    sentence_result_t expected_q[$];
    int unsigned      errors;
    int unsigned      lines_checked;
    int unsigned      lines_accepted;

    function new();
      clear_line();
      type_sel = nhsp_pkg::TYPE_RESET;
      heading  = '0;
    endfunction

    function void clear_line();
      line_pos  = '0;
      xor_acc   = '0;
      rx_ck     = '0;
      ck_fail   = 1'b0;
      star      = 1'b0;
      hex_end   = 1'b0;
      nul_seen  = 1'b0;
      num_go    = 1'b0;
      neg       = 1'b0;
      dot       = 1'b0;
      num_end   = 1'b0;
      commas    = '0;
      field_len = '0;
      acc       = 0;
      frac_cnt  = '0;
      round_up  = 1'b0;
      window    = '0;
      type_seen = 1'b0;
    endfunction

    function void set_type(logic [2:0] t);
      type_sel = nhsp_pkg::heading_type_t'(t);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic window_hit();
      case (type_sel)
        nhsp_pkg::TYPE_HDG:  return window[23:0] == "HDG";
        nhsp_pkg::TYPE_HDT:  return window[23:0] == "HDT";
        nhsp_pkg::TYPE_HDM:  return window[23:0] == "HDM";
        nhsp_pkg::TYPE_THS:  return window[23:0] == "THS";
        nhsp_pkg::TYPE_PHDT: return window == "PHDT";
        nhsp_pkg::TYPE_CHDT: return window == "CHDT";
        nhsp_pkg::TYPE_EHDT: return window == "EHDT";
        default:             return 1'b0;
      endcase
    endfunction

    function int unsigned capped(int unsigned v);
      return (v > TENTHS_CAP) ? TENTHS_CAP : v;
    endfunction

    // One character of the heading field, between the first and second comma.
    function void heading_char(logic [7:0] c);
      int unsigned d;
      if (num_end) return;
      if (!num_go && (c == nhsp_pkg::CHAR_SPACE ||
                      (c >= nhsp_pkg::CHAR_TAB && c <= nhsp_pkg::CHAR_CR))) return;
      if (!num_go && (c == nhsp_pkg::CHAR_PLUS || c == nhsp_pkg::CHAR_MINUS)) begin
        num_go = 1'b1;
        if (c == nhsp_pkg::CHAR_MINUS) neg = 1'b1;
        return;
      end
      if (c >= nhsp_pkg::CHAR_ZERO && c <= nhsp_pkg::CHAR_NINE) begin
        d = c - nhsp_pkg::CHAR_ZERO;
        num_go = 1'b1;
        if (!dot) begin
          acc = capped(acc * 10 + d * 10);
        end else if (frac_cnt == 2'd0) begin
          acc = capped(acc + d);
          frac_cnt = 2'd1;
        end else if (frac_cnt == 2'd1) begin
          if (d >= 5) round_up = 1'b1;
          frac_cnt = 2'd2;
        end
        return;
      end
      if (c == nhsp_pkg::CHAR_POINT && !dot) begin
        dot = 1'b1;
        num_go = 1'b1;
        return;
      end
      num_end = 1'b1;
    endfunction

    // Called for every accepted character word.
    function void note_byte(logic [7:0] b);
      sentence_result_t r;
      int unsigned      pos;
      int unsigned      v;
      logic [3:0]       nib;
      logic             is_hex;
      if (b == nhsp_pkg::CHAR_NEWLINE) begin
        r.ok = star && !ck_fail && (rx_ck == xor_acc) && type_seen;
        if (r.ok) begin
          v = 0;
          if (commas == 2'd2 && !neg) begin
            v = acc + round_up;
            if (v > 65535) v = 65535;
          end
          heading = v[15:0];
        end
        r.heading = heading;
        expected_q.push_back(r);
        clear_line();
        return;
      end
      if (nul_seen) return;
      if (b == nhsp_pkg::CHAR_NUL) begin
        nul_seen = 1'b1;
        return;
      end

      pos = line_pos;
      if (line_pos < 8'd255) line_pos++;

      // Checksum framing: '$', XOR span up to the star, hex digits after it.
      if (!ck_fail) begin
        if (pos == 0) begin
          if (b != nhsp_pkg::CHAR_DOLLAR) ck_fail = 1'b1;
        end else if (!star) begin
          if (b == nhsp_pkg::CHAR_STAR) star = 1'b1;
          else if (pos >= CHECK_SPAN) ck_fail = 1'b1;
          else xor_acc ^= b;
        end else if (!hex_end) begin
          is_hex = 1'b1;
          nib = '0;
          if (b >= "0" && b <= "9") nib = 4'(b - "0");
          else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 10);
          else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 10);
          else is_hex = 1'b0;
          if (is_hex) rx_ck = {rx_ck[3:0], nib};
          else hex_end = 1'b1;
        end
      end

      window = {window[23:0], b};
      if (window_hit()) type_seen = 1'b1;

      if (b == nhsp_pkg::CHAR_COMMA) begin
        if (commas < 2'd2) commas++;
      end else if (commas == 2'd1 && field_len < FIELD_MAX_CHARS) begin
        field_len++;
        heading_char(b);
      end
    endfunction

    // Called for every accepted result word.
    function void check_result(logic ok, logic [15:0] hdg);
      sentence_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no line pending: sentence_ok %0d heading_tenths %0d",
               ok, hdg);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      lines_checked++;
      if (e.ok) lines_accepted++;
      if (ok !== e.ok) begin
        $error("sentence_ok mismatch: expected %0d, actual %0d", e.ok, ok);
        errors++;
      end
      if (hdg !== e.heading) begin
        $error("heading_tenths mismatch: expected %0d, actual %0d", e.heading, hdg);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  byte_in = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        sentence_ok;
  logic [15:0] heading_tenths;

  heading_scoreboard sb;
  logic [7:0]    line_buf[$];
  logic [7:0]    body_buf[$];
  nhsp_pkg::heading_type_t cur_type = nhsp_pkg::TYPE_RESET;
  int            gap_mode = 0;
  int            stall_mode = 0;
  int            stall_left = 0;
  int            stall_pick;
  int unsigned   chars_sent = 0;
  int unsigned   phase_chars = 0;
  int unsigned   type_writes = 0;
  int unsigned   cycle_count = 0;

  nmea_heading_sentence_parser_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_in        (byte_in),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .sentence_ok    (sentence_ok),
    .heading_tenths (heading_tenths)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d lines outstanding.",
               cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Watch all three channels and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_type(cfg_data);
      if (byte_valid && !byte_stall) sb.note_byte(byte_in);
      if (result_valid && !result_stall) sb.check_result(sentence_ok, heading_tenths);
    end
  end

  // Mostly short idle stretches with a few long ones; mode 0 never idles.
  function automatic int idle_length(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 1) begin
      if (r < 80) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Result side stalls.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      stall_pick = idle_length(stall_mode);
      if (stall_pick > 0) begin
        stall_left   <= stall_pick - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Send one character word; returns right after the edge that takes it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = idle_length(gap_mode);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_in    <= b;
    do @(posedge clk); while (byte_stall);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    phase_chars += line_buf.size();
  endtask

  // Hold the character side until every pending result word is back. The
  // count is read between edges so the monitor has seen the last newline.
  task automatic drain_results();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_type(logic [2:0] t);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_type = nhsp_pkg::heading_type_t'(t);
    type_writes++;
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == nhsp_pkg::CHAR_STAR);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'("0" + n);
    return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic string type_name(nhsp_pkg::heading_type_t t);
    case (t)
      nhsp_pkg::TYPE_HDG:  return "HDG";
      nhsp_pkg::TYPE_HDT:  return "HDT";
      nhsp_pkg::TYPE_HDM:  return "HDM";
      nhsp_pkg::TYPE_THS:  return "THS";
      nhsp_pkg::TYPE_PHDT: return "PHDT";
      nhsp_pkg::TYPE_CHDT: return "CHDT";
      default:             return "EHDT";
    endcase
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) body_buf.push_back(s[i]);
  endfunction

  function automatic void push_digits(int n);
    repeat (n) body_buf.push_back(8'($urandom_range(48, 57)));
  endfunction

  function automatic void push_decimal();
    push_text($sformatf("%0d", $urandom_range(0, 999)));
    if ($urandom_range(0, 3) != 0) begin
      body_buf.push_back(nhsp_pkg::CHAR_POINT);
      push_digits($urandom_range(0, 3));
    end
  endfunction

  // Heading field text: plain, signed, padded, oversized and malformed forms.
  function automatic void push_heading_field();
    case ($urandom_range(0, 11))
      0: ;
      1: push_text($sformatf("%0d", $urandom_range(0, 359)));
      2, 3, 4: push_decimal();
      5: begin
        repeat ($urandom_range(1, 3)) body_buf.push_back(BLANKS[$urandom_range(0, 4)]);
        push_decimal();
      end
      6: begin
        body_buf.push_back($urandom_range(0, 1) ? nhsp_pkg::CHAR_PLUS :
                                                  nhsp_pkg::CHAR_MINUS);
        push_decimal();
      end
      7: push_digits($urandom_range(5, 9));
      8: begin
        push_digits($urandom_range(10, 18));
        if ($urandom_range(0, 1)) begin
          body_buf.push_back(nhsp_pkg::CHAR_POINT);
          push_digits(3);
        end
      end
      9: begin
        push_decimal();
        body_buf.push_back(text_char());
        push_digits(2);
      end
      10: begin
        push_text($sformatf("%0d.", $urandom_range(0, 99)));
        push_digits(1);
        body_buf.push_back(nhsp_pkg::CHAR_POINT);
        push_digits(1);
      end
      default: begin
        body_buf.push_back(nhsp_pkg::CHAR_POINT);
        push_digits($urandom_range(1, 3));
      end
    endcase
  endfunction

  // Directed line: '$', body, star and the correct uppercase checksum.
  function automatic void load_checked(string body);
    logic [7:0] cs;
    cs = '0;
    line_buf.delete();
    line_buf.push_back(nhsp_pkg::CHAR_DOLLAR);
    foreach (body[i]) begin
      line_buf.push_back(body[i]);
      cs ^= body[i];
    end
    line_buf.push_back(nhsp_pkg::CHAR_STAR);
    line_buf.push_back(hex_char(cs[7:4], 1'b0));
    line_buf.push_back(hex_char(cs[3:0], 1'b0));
    line_buf.push_back(nhsp_pkg::CHAR_NEWLINE);
  endfunction

  function automatic void load_text(string s);
    line_buf.delete();
    foreach (s[i]) line_buf.push_back(s[i]);
  endfunction

  // Random line: mostly valid sentences, the rest broken sentences or noise.
  function automatic void build_line();
    int            kind;
    int            target;
    logic [7:0]    cs;
    logic [7:0]    c;
    nhsp_pkg::heading_type_t t;
    string         name;
    kind = $urandom_range(0, 99);
    line_buf.delete();
    body_buf.delete();

    if (kind >= 92) begin
      repeat ($urandom_range(0, 12)) begin
        do c = 8'($urandom_range(0, 255)); while (c == nhsp_pkg::CHAR_NEWLINE);
        line_buf.push_back(c);
      end
      line_buf.push_back(nhsp_pkg::CHAR_NEWLINE);
      return;
    end

    if (cur_type != nhsp_pkg::TYPE_NONE && $urandom_range(0, 3) != 0) t = cur_type;
    else t = nhsp_pkg::heading_type_t'($urandom_range(0, 6));
    name = type_name(t);
    if (name.len() == 3 && $urandom_range(0, 1)) begin
      repeat (2) body_buf.push_back(8'($urandom_range(65, 90)));
    end
    push_text(name);
    body_buf.push_back(nhsp_pkg::CHAR_COMMA);
    push_heading_field();
    repeat ($urandom_range(0, 3)) begin
      body_buf.push_back(nhsp_pkg::CHAR_COMMA);
      repeat ($urandom_range(0, 5)) body_buf.push_back(text_char());
    end

    // Push the star to either side of the end of the checked span.
    if (kind >= 84 && kind < 88) begin
      target = $urandom_range(CHECK_SPAN - 4, CHECK_SPAN + 3);
      while (body_buf.size() < target) body_buf.push_back(text_char());
    end

    cs = '0;
    foreach (body_buf[i]) cs ^= body_buf[i];
    if (kind >= 70 && kind < 76) cs ^= 8'($urandom_range(1, 255));

    if (kind >= 76 && kind < 80) begin
      do c = text_char(); while (c == nhsp_pkg::CHAR_DOLLAR);
      line_buf.push_back(c);
    end else begin
      line_buf.push_back(nhsp_pkg::CHAR_DOLLAR);
    end
    foreach (body_buf[i]) line_buf.push_back(body_buf[i]);

    if (!(kind >= 80 && kind < 84)) begin
      line_buf.push_back(nhsp_pkg::CHAR_STAR);
      case ($urandom_range(0, 9))
        0: begin
          line_buf.push_back(hex_char(cs[7:4], 1'b1));
          line_buf.push_back(hex_char(cs[3:0], 1'b1));
        end
        1: begin
          line_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
          line_buf.push_back(hex_char(cs[7:4], 1'b0));
          line_buf.push_back(hex_char(cs[3:0], 1'b0));
        end
        2: line_buf.push_back(hex_char(cs[3:0], 1'b0));
        3: ;
        default: begin
          line_buf.push_back(hex_char(cs[7:4], 1'b0));
          line_buf.push_back(hex_char(cs[3:0], 1'b0));
        end
      endcase
      case ($urandom_range(0, 3))
        0, 1: line_buf.push_back(nhsp_pkg::CHAR_CR);
        2: line_buf.push_back(text_char());
        default: ;
      endcase
    end
    line_buf.push_back(nhsp_pkg::CHAR_NEWLINE);

    if (kind >= 88 && kind < 92) begin
      line_buf.insert($urandom_range(0, line_buf.size() - 1), nhsp_pkg::CHAR_NUL);
    end
  endfunction

  initial begin
    int unsigned phase;
    logic [2:0]  t;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed lines under the reset type: empty line, rounding, negative,
    // saturation, missing commas, a NUL inside the line and a high-bit byte.
    gap_mode   = 1;
    stall_mode = 1;
    load_text("\n");
    send_line();
    load_checked("HDT,359.95,T");
    send_line();
    load_checked("HDT,-5");
    send_line();
    load_checked("HDT,99999,");
    send_line();
    load_checked("HDT");
    send_line();
    load_text("$HDT,1.2");
    line_buf.push_back(nhsp_pkg::CHAR_NUL);
    line_buf.push_back("x");
    line_buf.push_back(nhsp_pkg::CHAR_NEWLINE);
    send_line();
    line_buf.delete();
    line_buf.push_back(8'hFF);
    line_buf.push_back(nhsp_pkg::CHAR_NEWLINE);
    send_line();

    // Random phases, each under its own heading type and idle pattern.
    phase = 0;
    phase_chars = 0;
    while (chars_sent < CHAR_TARGET) begin
      if (phase_chars == 0) begin
        t = (phase < 8) ? PHASE_TYPES[phase] : 3'($urandom_range(0, 7));
        write_type(t);
        if (phase % 4 == 0) begin
          gap_mode   = 0;
          stall_mode = 0;
        end else begin
          gap_mode   = $urandom_range(1, 2);
          stall_mode = $urandom_range(1, 2);
        end
      end
      build_line();
      send_line();
      if (phase_chars >= PHASE_CHARS) begin
        phase++;
        phase_chars = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d characters over %0d heading type settings.",
             chars_sent, type_writes);
    $display("Checked %0d result words, %0d of them for accepted sentences.",
             sb.lines_checked, sb.lines_accepted);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
